// ===== rtl/text_console_character_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Text console character engine assertion macros
// Shared assertion forms for the console RTL: same-cycle and next-cycle
// implications under a clock and an active-high reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHARACTER_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CHARACTER_ENGINE_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent.
`define TCE_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define TCE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tce_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console package
// Request and response payloads, cell type, sequencer states and codes.
// ----------------------------------------------------------------------------
package tce_pkg;

   typedef logic [15:0] cell_type;

   typedef struct packed {
      logic       op;
      logic [7:0] char_code;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
      logic [15:0] cell_data;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DISPATCH,
      ST_TAB,
      ST_SCROLL,
      ST_FLUSH,
      ST_CLEAR,
      ST_DONE
   } state_type;

   // request operations
   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // control characters
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // configuration registers
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOREGROUND = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKGROUND = 1'b1;

   localparam logic [3:0] FG_RESET = 4'hF;
   localparam logic [3:0] BG_RESET = 4'h0;

   // blank cell in the reset colors
   localparam cell_type RESET_CELL = {BG_RESET, FG_RESET, 8'h00};

endpackage

// ===== rtl/tce_cell_ram.sv =====
// ----------------------------------------------------------------------------
// Text console cell store
// Single write port, single read port screen memory with registered read.
// ----------------------------------------------------------------------------
module tce_cell_ram #(
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  tce_pkg::cell_type        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output tce_pkg::cell_type        rd_data
);
   import tce_pkg::*;

   cell_type mem_ff [DEPTH];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/text_console_character_engine.sv =====
// ----------------------------------------------------------------------------
// Text console character engine
// Keeps a ROWS x COLUMNS screen of 16-bit cells (background nibble, foreground
// nibble, character byte) and a cursor, and takes one request at a time: a put
// interprets tab, CR, LF, backspace, form feed and vertical tab and writes any
// other byte at the cursor; a read returns one cell. Every request yields one
// response with the cursor after it. All work runs through one sequencer that
// walks a single address counter over a memory with one write and one read
// port, so the memory ports set the cost. A read, a printable byte, CR or
// backspace without a scroll goes from dispatch to the response register; a
// tab steps the column in its own state; LF without a scroll clears the next
// row; form feed clears the whole screen; any request that scrolls copies
// each cell below the first row up one row, then flushes the last copy and
// clears the last row. After reset a clearing pass fills the screen with
// blank cells while requests stall; configuration writes are taken meanwhile.
// The response sits in an output register, so the next request is accepted
// while a finished response waits to be taken.
// ----------------------------------------------------------------------------
`include "text_console_character_engine_defines.svh"

module text_console_character_engine #(
   parameter int COLUMNS    = 80,
   parameter int ROWS       = 25,
   parameter int TAB_SPACES = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  tce_pkg::req_type                 req_data,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output tce_pkg::rsp_type                 rsp_data,
   // configuration writes
   input  logic                             csr_wr_en,
   input  logic [tce_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tce_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tce_pkg::*;

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int IW = $clog2(CELL_COUNT);      // memory index
   localparam int AW = $clog2(CELL_COUNT + 1);  // linear address incl. end
   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLUMNS + 1);     // column may equal COLUMNS
   localparam int TW = $clog2(TAB_SPACES + 1);

   localparam logic [AW-1:0] CELLS_A     = AW'(CELL_COUNT);
   localparam logic [AW-1:0] LAST_CELL_A = AW'(CELL_COUNT - 1);
   localparam logic [AW-1:0] LAST_BASE_A = AW'(CELL_COUNT - COLUMNS);
   localparam logic [AW-1:0] COLS_A      = AW'(COLUMNS);
   localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);
   localparam logic [CW-1:0] COLS_C      = CW'(COLUMNS);
   localparam logic [TW-1:0] TAB_C       = TW'(TAB_SPACES);

   // Sequencer and cursor state
   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] base_ff, base_in;     // row_ff * COLUMNS, kept incrementally
   logic [CW-1:0] col_ff, col_in;
   logic [TW-1:0] tab_cnt_ff, tab_cnt_in;
   logic [AW-1:0] walk_ff, walk_in;     // shared sweep address
   logic [AW-1:0] end_ff, end_in;       // end of a clear sweep

   // Scroll copy: read issued one cycle, written the next
   logic          copy_ff, copy_in;
   logic [IW-1:0] copy_addr_ff, copy_addr_in;

   // Response register
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   // Colors
   logic [3:0]    fg_ff, fg_in;
   logic [3:0]    bg_ff, bg_in;

   // Memory ports
   logic          seq_we;
   logic [IW-1:0] seq_waddr;
   cell_type      seq_wdata;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   cell_type      mem_wdata;
   logic          mem_re;
   logic [IW-1:0] mem_raddr;
   cell_type      rd_data;

   // Shared datapath terms
   logic [7:0]     attr;
   cell_type       fill_cell;
   cell_type       space_cell;
   logic [AW-1:0]  cur_addr;
   logic           cur_in_range;
   logic           row_last;
   logic           col_wrap;
   logic           tab_go;
   logic [IW+10:0] idx_wide;
   logic           read_in_range;
   logic           rsp_load;
   logic [RW+4:0]  row_wide;
   logic [CW+6:0]  col_wide;

   assign attr          = {bg_ff, fg_ff};
   assign fill_cell     = {attr, 8'h00};
   assign space_cell    = {attr, CH_SPACE};
   assign cur_addr      = base_ff + AW'(col_ff);
   assign cur_in_range  = cur_addr < CELLS_A;
   assign row_last      = row_ff == LAST_ROW;
   assign col_wrap      = ((CW+1)'(col_ff) + 1'b1) >= (CW+1)'(COLUMNS);
   assign tab_go        = (col_ff < COLS_C) && (tab_cnt_ff < TAB_C);
   assign idx_wide      = (IW+11)'(req_ff.cell_index);
   assign read_in_range = idx_wide < (IW+11)'(CELL_COUNT);
   assign rsp_load      = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign row_wide      = (RW+5)'(row_ff);
   assign col_wide      = (CW+7)'(col_ff);

   // Next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      col_in       = col_ff;
      tab_cnt_in   = tab_cnt_ff;
      walk_in      = walk_ff;
      end_in       = end_ff;
      copy_in      = 1'b0;
      copy_addr_in = copy_addr_ff;

      unique case (state_ff)
         ST_INIT: begin
            // blank every cell after reset
            walk_in = walk_ff + 1'b1;
            if (walk_ff == LAST_CELL_A) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (req_ff.op == OP_READ) begin
               state_in = ST_DONE;
            end else begin
               unique case (req_ff.char_code) inside
                  CH_TAB: begin
                     tab_cnt_in = '0;
                     state_in   = ST_TAB;
                  end
                  CH_CR, CH_LF: begin
                     if (req_ff.char_code == CH_LF) begin
                        col_in = '0;
                     end
                     if (row_last) begin
                        // scroll, which also blanks the last row
                        walk_in  = COLS_A;
                        state_in = ST_SCROLL;
                     end else begin
                        row_in  = row_ff + 1'b1;
                        base_in = base_ff + COLS_A;
                        if (req_ff.char_code == CH_LF) begin
                           walk_in  = base_ff + COLS_A;
                           end_in   = base_ff + COLS_A + COLS_A;
                           state_in = ST_CLEAR;
                        end else begin
                           state_in = ST_DONE;
                        end
                     end
                  end
                  CH_BS: begin
                     if (col_ff != '0) begin
                        col_in = col_ff - 1'b1;
                     end
                     state_in = ST_DONE;
                  end
                  CH_FF: begin
                     walk_in  = '0;
                     end_in   = CELLS_A;
                     state_in = ST_CLEAR;
                  end
                  CH_VT: begin
                     row_in   = LAST_ROW;
                     base_in  = LAST_BASE_A;
                     walk_in  = LAST_BASE_A;
                     end_in   = CELLS_A;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     // printable byte: advance, wrap to the next row
                     if (col_wrap) begin
                        col_in = '0;
                        if (row_last) begin
                           walk_in  = COLS_A;
                           state_in = ST_SCROLL;
                        end else begin
                           row_in   = row_ff + 1'b1;
                           base_in  = base_ff + COLS_A;
                           state_in = ST_DONE;
                        end
                     end else begin
                        col_in   = col_ff + 1'b1;
                        state_in = ST_DONE;
                     end
                  end
               endcase
            end
         end
         ST_TAB: begin
            if (tab_go) begin
               col_in     = col_ff + 1'b1;
               tab_cnt_in = tab_cnt_ff + 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCROLL: begin
            // read one row ahead, write it back in the next cycle
            walk_in      = walk_ff + 1'b1;
            copy_in      = 1'b1;
            copy_addr_in = IW'(walk_ff - COLS_A);
            if (walk_ff == LAST_CELL_A) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            walk_in  = LAST_BASE_A;
            end_in   = CELLS_A;
            state_in = ST_CLEAR;
         end
         ST_CLEAR: begin
            walk_in = walk_ff + 1'b1;
            if (walk_ff == end_ff - 1'b1) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: memory commands and request stall
   always_comb begin
      seq_we    = 1'b0;
      seq_waddr = cur_addr[IW-1:0];
      seq_wdata = space_cell;
      mem_re    = 1'b0;
      mem_raddr = walk_ff[IW-1:0];
      req_stall = 1'b1;

      unique case (state_ff)
         ST_INIT: begin
            seq_we    = 1'b1;
            seq_waddr = walk_ff[IW-1:0];
            seq_wdata = RESET_CELL;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_DISPATCH: begin
            if (req_ff.op == OP_READ) begin
               mem_re    = read_in_range;
               mem_raddr = idx_wide[IW-1:0];
            end else begin
               unique case (req_ff.char_code) inside
                  CH_TAB, CH_CR, CH_LF, CH_FF, CH_VT: begin
                     seq_we = 1'b0;
                  end
                  CH_BS: begin
                     seq_we = (col_ff != '0) && cur_in_range;
                  end
                  default: begin
                     // drop writes that land past the screen
                     seq_we    = cur_in_range;
                     seq_wdata = {attr, req_ff.char_code};
                  end
               endcase
            end
         end
         ST_TAB: begin
            seq_we = tab_go && cur_in_range;
         end
         ST_SCROLL: begin
            mem_re = 1'b1;
         end
         ST_CLEAR: begin
            seq_we    = 1'b1;
            seq_waddr = walk_ff[IW-1:0];
            seq_wdata = fill_cell;
         end
         ST_FLUSH, ST_DONE: begin
            seq_we = 1'b0;
         end
         default: begin
            seq_we = 1'b0;
         end
      endcase
   end

   // Pending scroll copy takes the write port
   assign mem_we    = seq_we | copy_ff;
   assign mem_waddr = copy_ff ? copy_addr_ff : seq_waddr;
   assign mem_wdata = copy_ff ? rd_data : seq_wdata;

   // Response register and configuration
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_valid_in         = 1'b1;
         rsp_in.cursor_row    = row_wide[4:0];
         rsp_in.cursor_col    = col_wide[6:0];
         rsp_in.cell_data     = ((req_ff.op == OP_READ) && read_in_range) ? rd_data : '0;
      end

      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FOREGROUND: fg_in = csr_wdata;
            CSR_BACKGROUND: bg_in = csr_wdata;
            default: begin
               fg_in = fg_ff;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         walk_ff      <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
         col_ff       <= '0;
         copy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fg_ff        <= FG_RESET;
         bg_ff        <= BG_RESET;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         row_ff       <= row_in;
         base_ff      <= base_in;
         col_ff       <= col_in;
         copy_ff      <= copy_in;
         rsp_valid_ff <= rsp_valid_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      tab_cnt_ff   <= tab_cnt_in;
      end_ff       <= end_in;
      copy_addr_ff <= copy_addr_in;
      rsp_ff       <= rsp_in;
   end

   tce_cell_ram #(
      .DEPTH (CELL_COUNT)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TCE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "request accepted but not held off next cycle")
   `TCE_ASSERT_IMPL(a_row_bound, clock, reset, 1'b1, row_ff <= LAST_ROW, "cursor row past last row")
   `TCE_ASSERT_IMPL(a_col_bound, clock, reset, 1'b1, col_ff <= COLS_C, "cursor column past width")
   `TCE_ASSERT_IMPL(a_base_tracks_row, clock, reset, 1'b1, base_ff == AW'(row_ff * COLUMNS), "row base out of step with row")
   `TCE_ASSERT_IMPL(a_one_writer, clock, reset, copy_ff, !seq_we, "scroll copy collides with a sequencer write")
   `TCE_ASSERT_NEXT(a_done_holds, clock, reset, (state_ff == ST_DONE) && rsp_valid_ff && rsp_stall, state_ff == ST_DONE, "response overwritten while stalled")

endmodule
